/* src/assert_macros.svh */
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/apl_pkg.sv */
// ----------------------------------------------------------------------------
// apl_pkg
// shared constants, status codes and state types of the piecewise-linear table
// ----------------------------------------------------------------------------
package apl_pkg;

  localparam int PTS_PER_CURVE_DEF = 10;
  localparam int NUM_CURVES_DEF    = 16;
  localparam int SIZE_W            = 48;
  localparam int TIME_W            = 40;
  localparam int STAT_W            = 3;
  localparam int CIDX_IN_W         = 4;

  localparam logic [STAT_W-1:0] ST_NODATA = 3'd0;
  localparam logic [STAT_W-1:0] ST_EXACT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_INTERP = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXTRAP = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZERO   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_CNT, S_SCAN_A, S_SCAN_D, S_DECIDE, S_UPD,
    S_SH_RD, S_SH_WR, S_INS, S_M1S, S_M1W, S_M2S, S_M2W, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE, MD_MUL, MD_DIV
  } md_state_t;

  typedef struct packed {
    logic mem_we;
    logic cnt_we;
  } store_ctl_t;

endpackage

/* src/apl_muldiv.sv */
// ----------------------------------------------------------------------------
// apl_muldiv
// serial floor(a*b/d) with saturation: shift-add multiply, restoring divide
// ----------------------------------------------------------------------------
module apl_muldiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [apl_pkg::TIME_W-1:0] a,
  input  logic [apl_pkg::SIZE_W-1:0] b,
  input  logic [apl_pkg::SIZE_W-1:0] d,
  output logic                       done,
  output logic [apl_pkg::TIME_W-1:0] q
);
  import apl_pkg::*;

  localparam int PROD_W = TIME_W + SIZE_W;
  localparam int STEP_W = $clog2(PROD_W + 1);

  md_state_t          ph_r, ph_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [PROD_W-1:0]  acc_r;
  logic [PROD_W-1:0]  mcand_r;
  logic [SIZE_W-1:0]  mplier_r;
  logic [SIZE_W-1:0]  dvs_r;
  logic [SIZE_W-1:0]  rem_r;
  logic [TIME_W-1:0]  quo_r;
  logic               sat_r;
  logic               done_r;
  logic [SIZE_W:0]    trial;
  logic               ge;
  logic [SIZE_W:0]    diff;
  logic               mul_last;
  logic               div_last;

  assign trial    = {rem_r, acc_r[PROD_W-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  assign diff     = trial - {1'b0, dvs_r};
  assign mul_last = step_r == STEP_W'(SIZE_W - 1);
  assign div_last = step_r == '0;

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      MD_IDLE: if (start) ph_nxt = MD_MUL;
      MD_MUL:  if (mul_last) ph_nxt = MD_DIV;
      MD_DIV:  if (div_last) ph_nxt = MD_IDLE;
      default: ph_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    done = done_r;
    q    = sat_r ? '1 : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MD_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == MD_DIV) && div_last;
    end
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      MD_IDLE: begin
        acc_r    <= '0;
        mcand_r  <= PROD_W'(a);
        mplier_r <= b;
        dvs_r    <= d;
        step_r   <= '0;
      end
      MD_MUL: begin
        if (mplier_r[0]) acc_r <= acc_r + mcand_r;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        if (mul_last) begin
          step_r <= STEP_W'(PROD_W - 1);
          rem_r  <= '0;
          quo_r  <= '0;
          sat_r  <= 1'b0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
      MD_DIV: begin
        rem_r  <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        acc_r  <= acc_r << 1;
        if (step_r >= STEP_W'(TIME_W)) begin
          sat_r <= sat_r | ge;
        end else begin
          quo_r <= {quo_r[TIME_W-2:0], ge};
        end
        step_r <= step_r - 1'b1;
      end
      default: begin
        step_r <= '0;
      end
    endcase
  end

endmodule

/* src/apl_store.sv */
// ----------------------------------------------------------------------------
// apl_store
// point memories (one read, one write port, registered read) and point counts
// ----------------------------------------------------------------------------
module apl_store #(
  parameter int PTS_PER_CURVE = apl_pkg::PTS_PER_CURVE_DEF,
  parameter int NUM_CURVES    = apl_pkg::NUM_CURVES_DEF,
  localparam int DEPTH  = NUM_CURVES * PTS_PER_CURVE,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CIDX_W = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1,
  localparam int CNT_W  = $clog2(PTS_PER_CURVE + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  apl_pkg::store_ctl_t        ctl,
  input  logic [ADDR_W-1:0]          rd_addr,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [apl_pkg::SIZE_W-1:0] wr_size,
  input  logic [apl_pkg::TIME_W-1:0] wr_time,
  output logic [apl_pkg::SIZE_W-1:0] rd_size,
  output logic [apl_pkg::TIME_W-1:0] rd_time,
  input  logic [CIDX_W-1:0]          cnt_curve,
  input  logic [CNT_W-1:0]           cnt_wdata,
  output logic [CNT_W-1:0]           cnt_rdata
);
  import apl_pkg::*;

  logic [SIZE_W-1:0] size_mem [DEPTH];
  logic [TIME_W-1:0] time_mem [DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [NUM_CURVES];
  logic [NUM_CURVES-1:0] cvalid_r;
  logic [CNT_W-1:0]  cnt_q_r;
  logic              cv_q_r;
  logic [SIZE_W-1:0] rd_size_r;
  logic [TIME_W-1:0] rd_time_r;

  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      size_mem[wr_addr] <= wr_size;
      time_mem[wr_addr] <= wr_time;
    end
    rd_size_r <= size_mem[rd_addr];
    rd_time_r <= time_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_we) cnt_mem[cnt_curve] <= cnt_wdata;
    cnt_q_r <= cnt_mem[cnt_curve];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= '0;
      cv_q_r   <= 1'b0;
    end else begin
      if (ctl.cnt_we) cvalid_r[cnt_curve] <= 1'b1;
      cv_q_r <= cvalid_r[cnt_curve];
    end
  end

  assign rd_size   = rd_size_r;
  assign rd_time   = rd_time_r;
  assign cnt_rdata = cv_q_r ? cnt_q_r : '0;

endmodule

/* src/adaptive_piecewise_linear_table.sv */
// ----------------------------------------------------------------------------
// adaptive_piecewise_linear_table
// per-curve sorted (size, time) points with averaging, insertion, eviction
// and exact / interpolated / extrapolated estimates
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | start, busy        | in_mode, in_curve_index, in_job_size,
//           |                    | in_measured_time
//  out      | out_valid (strobe) | out_estimated_time, out_status
//
//  a beat is taken when start is high and busy low; busy stays high until done
//  scan of a curve: count read, a read and a check per stored point, last
//  check, decision; an add then reads and writes each shifted point and
//  inserts, an update writes once; every estimate ends in the result strobe
//  each floor(a*b/d) on the shared serial unit steps through start, the
//  multiplier bits, the product bits and done; interpolation uses it twice
//  reset is synchronous, counts clear at once; the receiver cannot stall, a
//  result strobe lasts one cycle
// ----------------------------------------------------------------------------
module adaptive_piecewise_linear_table #(
  parameter int PTS_PER_CURVE = apl_pkg::PTS_PER_CURVE_DEF,
  parameter int NUM_CURVES    = apl_pkg::NUM_CURVES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [apl_pkg::CIDX_IN_W-1:0] in_curve_index,
  input  logic [apl_pkg::SIZE_W-1:0]    in_job_size,
  input  logic [apl_pkg::TIME_W-1:0]    in_measured_time,
  output logic                          out_valid,
  output logic [apl_pkg::TIME_W-1:0]    out_estimated_time,
  output logic [apl_pkg::STAT_W-1:0]    out_status
);
  import apl_pkg::*;

  localparam int DEPTH  = NUM_CURVES * PTS_PER_CURVE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIDX_W = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
  localparam int CNT_W  = $clog2(PTS_PER_CURVE + 1);

  state_t            state_r, state_nxt;
  logic              mode_r;
  logic              ok_r;
  logic [CIDX_W-1:0] cur_r;
  logic [SIZE_W-1:0] n_r;
  logic [TIME_W-1:0] t_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  idx_r;
  logic              hit_r;
  logic              eq_r;
  logic [CNT_W-1:0]  l_r;
  logic [CNT_W-1:0]  rep_r;
  logic [SIZE_W-1:0] best_r;
  logic [SIZE_W-1:0] s0_r, s1_r, prev_s_r, pp_s_r;
  logic [TIME_W-1:0] t0_r, t1_r, prev_t_r;
  logic [CNT_W-1:0]  ins_r;
  logic              down_r;
  logic [TIME_W-1:0] op_a_r;
  logic [SIZE_W-1:0] op_b_r, op_d_r;
  logic              interp_r;
  logic [TIME_W-1:0] v0_r;
  logic [TIME_W-1:0] res_time_r;
  logic [STAT_W-1:0] res_stat_r;

  store_ctl_t        ctl;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [SIZE_W-1:0] wr_size, rd_size;
  logic [TIME_W-1:0] wr_time, rd_time;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              md_start, md_done;
  logic [TIME_W-1:0] md_q;

  logic [SIZE_W-1:0] span;
  logic [TIME_W:0]   avg_sum;
  logic [TIME_W:0]   int_sum;
  logic              full;
  logic [CNT_W-1:0]  rep_v;
  logic              add_new;
  logic              est_short;

  assign base      = ADDR_W'(32'(cur_r) * PTS_PER_CURVE);
  assign span      = rd_size - pp_s_r;
  assign avg_sum   = {1'b0, t1_r} + {1'b0, t_r};
  assign int_sum   = {1'b0, v0_r} + {1'b0, md_q};
  assign full      = cnt_r == CNT_W'(PTS_PER_CURVE);
  assign rep_v     = full ? rep_r : cnt_r;
  assign add_new   = !mode_r && ok_r && !(hit_r && eq_r);
  assign est_short = !ok_r || (cnt_r == '0) || (hit_r && eq_r) || (!hit_r && prev_s_r == '0);

  apl_store #(.PTS_PER_CURVE(PTS_PER_CURVE), .NUM_CURVES(NUM_CURVES)) u_store (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .rd_addr(rd_addr), .wr_addr(wr_addr), .wr_size(wr_size), .wr_time(wr_time),
    .rd_size(rd_size), .rd_time(rd_time),
    .cnt_curve(cur_r), .cnt_wdata(cnt_wdata), .cnt_rdata(cnt_rdata)
  );

  apl_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .start(md_start),
    .a(op_a_r), .b(op_b_r), .d(op_d_r), .done(md_done), .q(md_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_CRD;
      S_CRD:    state_nxt = S_CNT;
      S_CNT:    state_nxt = ok_r ? S_SCAN_A : S_DECIDE;
      S_SCAN_A: state_nxt = (idx_r < cnt_r) ? S_SCAN_D : S_DECIDE;
      S_SCAN_D: state_nxt = S_SCAN_A;
      S_DECIDE: begin
        if (!mode_r) begin
          if (!ok_r) state_nxt = S_IDLE;
          else if (hit_r && eq_r) state_nxt = S_UPD;
          else state_nxt = S_SH_RD;
        end else begin
          state_nxt = est_short ? S_OUT : S_M1S;
        end
      end
      S_SH_RD: begin
        if ((down_r && idx_r > ins_r) || (!down_r && idx_r < ins_r)) state_nxt = S_SH_WR;
        else state_nxt = S_INS;
      end
      S_SH_WR:  state_nxt = S_SH_RD;
      S_UPD:    state_nxt = S_IDLE;
      S_INS:    state_nxt = S_IDLE;
      S_M1S:    state_nxt = S_M1W;
      S_M1W:    if (md_done) state_nxt = interp_r ? S_M2S : S_OUT;
      S_M2S:    state_nxt = S_M2W;
      S_M2W:    if (md_done) state_nxt = S_OUT;
      S_OUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs and store controls
  always_comb begin
    busy               = state_r != S_IDLE;
    out_valid          = state_r == S_OUT;
    out_estimated_time = res_time_r;
    out_status         = res_stat_r;
    ctl                = '0;
    md_start           = (state_r == S_M1S) || (state_r == S_M2S);
    rd_addr            = base + ADDR_W'(idx_r);
    wr_addr            = base + ADDR_W'(idx_r);
    wr_size            = rd_size;
    wr_time            = rd_time;
    cnt_wdata          = cnt_r + 1'b1;
    case (state_r)
      S_SH_RD: rd_addr = down_r ? base + ADDR_W'(idx_r - 1'b1) : base + ADDR_W'(idx_r + 1'b1);
      S_SH_WR: ctl.mem_we = 1'b1;
      S_UPD: begin
        ctl.mem_we = 1'b1;
        wr_addr    = base + ADDR_W'(l_r);
        wr_size    = n_r;
        wr_time    = avg_sum[TIME_W:1];
      end
      S_INS: begin
        ctl.mem_we = 1'b1;
        wr_addr    = base + ADDR_W'(ins_r);
        wr_size    = n_r;
        wr_time    = t_r;
      end
      S_DECIDE: ctl.cnt_we = add_new && !full;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_r <= in_mode;
          ok_r   <= 32'(in_curve_index) < 32'(NUM_CURVES);
          cur_r  <= CIDX_W'(in_curve_index);
          n_r    <= in_job_size;
          t_r    <= in_measured_time;
        end
      end
      S_CNT: begin
        cnt_r    <= ok_r ? cnt_rdata : '0;
        l_r      <= ok_r ? cnt_rdata : '0;
        idx_r    <= '0;
        hit_r    <= 1'b0;
        eq_r     <= 1'b0;
        prev_s_r <= '0;
        prev_t_r <= '0;
        pp_s_r   <= '0;
        rep_r    <= CNT_W'(1);
        best_r   <= '0;
      end
      S_SCAN_D: begin
        if (!hit_r && rd_size >= n_r) begin
          hit_r <= 1'b1;
          eq_r  <= rd_size == n_r;
          l_r   <= idx_r;
          s1_r  <= rd_size;
          t1_r  <= rd_time;
          s0_r  <= prev_s_r;
          t0_r  <= prev_t_r;
        end
        if (idx_r >= CNT_W'(2)) begin
          if (idx_r == CNT_W'(2) || span < best_r) begin
            best_r <= span;
            rep_r  <= idx_r - 1'b1;
          end
        end
        pp_s_r   <= prev_s_r;
        prev_s_r <= rd_size;
        prev_t_r <= rd_time;
        idx_r    <= idx_r + 1'b1;
      end
      S_DECIDE: begin
        ins_r  <= (l_r <= rep_v) ? l_r : l_r - 1'b1;
        down_r <= l_r <= rep_v;
        idx_r  <= rep_v;
        res_time_r <= '0;
        res_stat_r <= ST_NODATA;
        if (ok_r && cnt_r != '0) begin
          if (hit_r && eq_r) begin
            res_time_r <= t1_r;
            res_stat_r <= ST_EXACT;
          end else if (!hit_r && prev_s_r == '0) begin
            res_stat_r <= ST_ZERO;
          end
        end
        if (!hit_r) begin
          op_a_r   <= prev_t_r;
          op_b_r   <= n_r;
          op_d_r   <= prev_s_r;
          interp_r <= 1'b0;
        end else begin
          op_a_r   <= t0_r;
          op_b_r   <= s1_r - n_r;
          op_d_r   <= s1_r - s0_r;
          interp_r <= 1'b1;
        end
      end
      S_SH_WR: idx_r <= down_r ? idx_r - 1'b1 : idx_r + 1'b1;
      S_M1W: begin
        if (md_done) begin
          if (interp_r) begin
            v0_r   <= md_q;
            op_a_r <= t1_r;
            op_b_r <= n_r - s0_r;
          end else begin
            res_time_r <= md_q;
            res_stat_r <= ST_EXTRAP;
          end
        end
      end
      S_M2W: begin
        if (md_done) begin
          res_time_r <= int_sum[TIME_W] ? '1 : int_sum[TIME_W-1:0];
          res_stat_r <= ST_INTERP;
        end
      end
      default: idx_r <= idx_r;
    endcase
  end

  `include "assert_macros.svh"

  `ASSERT_IMP(a_write_only_add, ctl.mem_we || ctl.cnt_we, !mode_r && ok_r)
  `ASSERT_IMP(a_out_only_est, out_valid, mode_r)
  `ASSERT_IMP(a_nodata_zero, out_valid && out_status == ST_NODATA, out_estimated_time == '0)
  `ASSERT_NXT(a_accept_busy, start && !busy, busy)

endmodule

/* tb/adaptive_piecewise_linear_table_tb.sv */
// ----------------------------------------------------------------------------
// adaptive_piecewise_linear_table_tb
// drives add and estimate commands into the piecewise-linear table, keeps a
// shadow copy of every curve and checks each estimate beat against it
// ----------------------------------------------------------------------------
module adaptive_piecewise_linear_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apl_pkg::*;

  localparam int MAXP = PTS_PER_CURVE_DEF;
  localparam int NCRV = NUM_CURVES_DEF;
  localparam int N_RAND = 1850;
  localparam int WATCHDOG = 20000;
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_EST = 1'b1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [TIME_W-1:0] est;
    logic [STAT_W-1:0] st;
  } est_t;

  typedef struct {
    logic m;
    logic [3:0] c;
    logic [SIZE_W-1:0] n;
    logic [TIME_W-1:0] t;
    logic chk;
    est_t want;
  } row_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic in_mode = 0;
  logic [CIDX_IN_W-1:0] in_curve_index = 0;
  logic [SIZE_W-1:0] in_job_size = 0;
  logic [TIME_W-1:0] in_measured_time = 0;
  logic busy, out_valid;
  logic [TIME_W-1:0] out_estimated_time;
  logic [STAT_W-1:0] out_status;

  logic [SIZE_W-1:0] sh_size [NCRV][MAXP];
  logic [TIME_W-1:0] sh_time [NCRV][MAXP];
  int sh_cnt [NCRV];
  est_t pending_est[$];
  est_t last_got;
  int errors = 0, n_items = 0, n_est = 0, idle_cyc = 0;
  bit quiet = 0;
  row_t rows[$];

  adaptive_piecewise_linear_table DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic logic [TIME_W-1:0] muldiv_sat(logic [TIME_W-1:0] a,
                                                   logic [SIZE_W-1:0] b,
                                                   logic [SIZE_W-1:0] d);
    logic [127:0] q;
    q = ({88'd0, a} * {80'd0, b}) / {80'd0, d};
    return (q > {88'd0, TIME_MAX}) ? TIME_MAX : q[TIME_W-1:0];
  endfunction

  function automatic int slot_of(int c, logic [SIZE_W-1:0] n);
    for (int i = 0; i < sh_cnt[c]; i++) if (sh_size[c][i] >= n) return i;
    return sh_cnt[c];
  endfunction

  task automatic shadow_add(int c, logic [SIZE_W-1:0] n, logic [TIME_W-1:0] t);
    int l, rep;
    logic [SIZE_W-1:0] best, d;
    logic [TIME_W:0] sum;
    l = slot_of(c, n);
    if (l < sh_cnt[c] && sh_size[c][l] == n) begin
      sum = {1'b0, sh_time[c][l]} + {1'b0, t};
      sh_time[c][l] = sum[TIME_W:1];
      return;
    end
    if (sh_cnt[c] == MAXP) begin
      best = sh_size[c][2] - sh_size[c][0];
      rep = 1;
      for (int i = 1; i + 1 < MAXP; i++) begin
        d = sh_size[c][i+1] - sh_size[c][i-1];
        if (d < best) begin
          best = d;
          rep = i;
        end
      end
    end else begin
      rep = sh_cnt[c];
      sh_cnt[c]++;
    end
    if (l <= rep) begin
      for (int i = rep; i > l; i--) begin
        sh_size[c][i] = sh_size[c][i-1];
        sh_time[c][i] = sh_time[c][i-1];
      end
    end else begin
      l--;
      for (int i = rep; i < l; i++) begin
        sh_size[c][i] = sh_size[c][i+1];
        sh_time[c][i] = sh_time[c][i+1];
      end
    end
    sh_size[c][l] = n;
    sh_time[c][l] = t;
  endtask

  function automatic est_t lookup(int c, logic [SIZE_W-1:0] n);
    est_t r;
    int l, k;
    logic [SIZE_W-1:0] s0, w, x;
    logic [TIME_W-1:0] t0;
    logic [TIME_W:0] v;
    r = '{est: '0, st: ST_NODATA};
    k = sh_cnt[c];
    if (k == 0) return r;
    l = slot_of(c, n);
    if (l < k && sh_size[c][l] == n) return '{est: sh_time[c][l], st: ST_EXACT};
    if (l == k) begin
      if (sh_size[c][k-1] == 0) return '{est: '0, st: ST_ZERO};
      return '{est: muldiv_sat(sh_time[c][k-1], n, sh_size[c][k-1]), st: ST_EXTRAP};
    end
    s0 = (l > 0) ? sh_size[c][l-1] : '0;
    t0 = (l > 0) ? sh_time[c][l-1] : '0;
    w = sh_size[c][l] - s0;
    x = n - s0;
    v = {1'b0, muldiv_sat(t0, w - x, w)} + {1'b0, muldiv_sat(sh_time[c][l], x, w)};
    r.est = v[TIME_W] ? TIME_MAX : v[TIME_W-1:0];
    r.st = ST_INTERP;
    return r;
  endfunction

  // beat acceptance, prediction and result checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        n_items++;
        if (in_mode == MODE_ADD) begin
          shadow_add(int'(in_curve_index), in_job_size, in_measured_time);
        end else begin
          pending_est.push_back(lookup(int'(in_curve_index), in_job_size));
        end
      end
      if (out_valid) begin
        n_est++;
        last_got = '{est: out_estimated_time, st: out_status};
        if (pending_est.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          est_t e;
          e = pending_est.pop_front();
          if (out_estimated_time !== e.est) begin
            $error("estimated_time exp %0d got %0d", e.est, out_estimated_time);
            errors++;
          end
          if (out_status !== e.st) begin
            $error("status exp %0d got %0d", e.st, out_status);
            errors++;
          end
        end
      end
      idle_cyc = ((start && !busy) || out_valid) ? 0 : idle_cyc + 1;
      if (idle_cyc >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send(logic m, logic [3:0] c, logic [SIZE_W-1:0] n,
                      logic [TIME_W-1:0] t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    start <= 1;
    in_mode <= m;
    in_curve_index <= c;
    in_job_size <= n;
    in_measured_time <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] rnd_size(int c);
    case ($urandom_range(0, 7))
      0: return SIZE_W'({$urandom, $urandom});
      1: return 48'hFFFF_FFFF_FFFF - SIZE_W'($urandom_range(0, 3));
      2: return SIZE_W'($urandom_range(0, 3));
      3: return (sh_cnt[c] > 0) ? sh_size[c][$urandom_range(0, sh_cnt[c]-1)] : 48'd5;
      default: return SIZE_W'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rnd_time();
    case ($urandom_range(0, 5))
      0: return TIME_MAX - TIME_W'($urandom_range(0, 3));
      1: return TIME_W'({$urandom, $urandom});
      2: return '0;
      default: return TIME_W'($urandom_range(0, 100000));
    endcase
  endfunction

  task automatic row(logic m, logic [3:0] c, logic [SIZE_W-1:0] n,
                     logic [TIME_W-1:0] t, logic chk, est_t w);
    rows.push_back('{m: m, c: c, n: n, t: t, chk: chk, want: w});
  endtask

  initial begin
    logic [3:0] c;
    est_t none;
    none = '{est: '0, st: ST_NODATA};
    for (int i = 0; i < NCRV; i++) sh_cnt[i] = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    row(MODE_EST, 4'd0, 48'd100, '0, 1, none);
    row(MODE_EST, 4'd15, '1, '1, 1, none);
    row(MODE_ADD, 4'd1, 48'd0, 40'd50, 0, none);
    row(MODE_EST, 4'd1, 48'd7, '0, 1, '{est: '0, st: ST_ZERO});
    row(MODE_EST, 4'd1, 48'd0, '0, 1, '{est: 40'd50, st: ST_EXACT});
    row(MODE_ADD, 4'd2, 48'd10, 40'd100, 0, none);
    row(MODE_EST, 4'd2, 48'd5, '0, 1, '{est: 40'd50, st: ST_INTERP});
    row(MODE_EST, 4'd2, 48'd20, '0, 1, '{est: 40'd200, st: ST_EXTRAP});
    row(MODE_ADD, 4'd3, 48'd1, '1, 0, none);
    row(MODE_EST, 4'd3, '1, '0, 1, '{est: TIME_MAX, st: ST_EXTRAP});
    row(MODE_ADD, 4'd2, 48'd10, 40'd201, 0, none);
    row(MODE_EST, 4'd2, 48'd10, '0, 1, '{est: 40'd150, st: ST_EXACT});
    row(MODE_ADD, 4'd15, '1, '1, 0, none);
    row(MODE_EST, 4'd15, '1, '0, 1, '{est: TIME_MAX, st: ST_EXACT});
    // fill one curve past capacity to force eviction
    for (int i = 0; i < 12; i++) row(MODE_ADD, 4'd4, 48'(i * i * 7 + 3), 40'(i * 31), 0, none);
    row(MODE_EST, 4'd4, 48'd50, '0, 0, none);
    foreach (rows[i]) begin
      send(rows[i].m, rows[i].c, rows[i].n, rows[i].t);
      while (pending_est.size() != 0) @(negedge clk);
      if (rows[i].chk && rows[i].m == MODE_EST) begin
        // typed-in expectation for this row
        if (last_got.est !== rows[i].want.est) begin
          $error("row %0d estimated_time exp %0d got %0d", i, rows[i].want.est, last_got.est);
          errors++;
        end
        if (last_got.st !== rows[i].want.st) begin
          $error("row %0d status exp %0d got %0d", i, rows[i].want.st, last_got.st);
          errors++;
        end
      end
    end

    for (int k = 0; k < N_RAND; k++) begin
      if (k > N_RAND - 150) quiet = 1;
      c = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(5, 7));
      if ($urandom_range(0, 1)) send(MODE_ADD, c, rnd_size(c), rnd_time());
      else send(MODE_EST, c, rnd_size(c), rnd_time());
    end
    start <= 0;
    while (pending_est.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    $display("covered %0d command beats, %0d estimate beats checked", n_items, n_est);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/apl_pkg.sv
src/apl_muldiv.sv
src/apl_store.sv
src/adaptive_piecewise_linear_table.sv
tb/adaptive_piecewise_linear_table_tb.sv
